[rtl/ifb_pkg.sv]
`timescale 1ns / 1ps

package ifb_pkg;

    // Default geometry of the allocation map
    localparam int unsigned BLOCK_BYTES_DEF    = 1024;
    localparam int unsigned MAX_MAP_BLOCKS_DEF = 8;
    localparam int unsigned WORD_BITS_DEF      = 64;

    localparam int unsigned BYTE_BITS = 8;

    // Fixed field widths
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned NUM_W    = 17;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_W    = 4;
    localparam int unsigned TDATA_W  = 24;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [CFG_W-1:0] MAP_BLOCKS_RST = 4'd8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_MARK  = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_ALLOC = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SPLIT_A,
        S_SPLIT_B,
        S_ISSUE,
        S_MODIFY,
        S_SCAN,
        S_PICK,
        S_DONE
    } state_t;

endpackage

[rtl/ifb_ram.sv]
`timescale 1ns / 1ps

module ifb_ram #(
    parameter int unsigned WIDTH  = 64,
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/ifb_split.sv]
`timescale 1ns / 1ps

// Split a bit index into word and bit position: multiply by the scaled
// reciprocal of WORD_BITS, then fix the quotient by one step.
// Two register stages; outputs are corrected from the second stage.
module ifb_split #(
    parameter int unsigned WORD_BITS = ifb_pkg::WORD_BITS_DEF,
    parameter int unsigned ADDR_W    = 10,
    parameter int unsigned BIT_W     = $clog2(WORD_BITS)
) (
    input  logic                      clk,
    input  logic [ifb_pkg::NUM_W-1:0] idx,
    output logic [ADDR_W-1:0]         word_idx,
    output logic [BIT_W-1:0]          bit_idx
);

    localparam int unsigned NW    = ifb_pkg::NUM_W;
    localparam int unsigned RECIP = (1 << NW) / WORD_BITS;

    logic [2*NW-1:0] prod_reg;
    logic [NW-1:0]   idx_d_reg;
    logic [NW-1:0]   quot_reg;
    logic [BIT_W:0]  rem_reg;
    logic [NW-1:0]   quot_est;
    logic [NW-1:0]   rem_full;

    assign quot_est = prod_reg[2*NW-1:NW];
    assign rem_full = idx_d_reg - NW'(quot_est * NW'(WORD_BITS));

    always_ff @(posedge clk)
    begin
        prod_reg  <= (2*NW)'(idx) * (2*NW)'(RECIP);
        idx_d_reg <= idx;
        quot_reg  <= quot_est;
        rem_reg   <= rem_full[BIT_W:0];
    end

    // estimate is low by at most one word
    always_comb
    begin
        if (rem_reg >= (BIT_W+1)'(WORD_BITS))
        begin
            word_idx = ADDR_W'(quot_reg + NW'(1));
            bit_idx  = BIT_W'(rem_reg - (BIT_W+1)'(WORD_BITS));
        end
        else
        begin
            word_idx = ADDR_W'(quot_reg);
            bit_idx  = BIT_W'(rem_reg);
        end
    end

endmodule

[rtl/inode_bitmap_allocator_top.sv]
// Steps: allocate scans map words from the RAM port, one word per cycle, up to WORD_COUNT
//   (1024 by default), then picks the lowest clear bit and writes that word back with it set.
//   Free and mark used go through index split, read and modify-write; other codes go to the result.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: rst_n clears control state and sets map_blocks_reg to 8, then a clearing
//   pass writes zero to every map word with s_tready low.
`timescale 1ns / 1ps

module inode_bitmap_allocator_top #(
    parameter int unsigned BLOCK_BYTES    = ifb_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned MAX_MAP_BLOCKS = ifb_pkg::MAX_MAP_BLOCKS_DEF,
    parameter int unsigned WORD_BITS      = ifb_pkg::WORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ifb_pkg::TDATA_W-1:0]  s_tdata,   // [1:0] func, [18:2] object_number
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ifb_pkg::TDATA_W-1:0]  m_tdata,   // [1:0] status, [18:2] granted_number
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ifb_pkg::APB_AW-1:0]   paddr,
    input  logic [ifb_pkg::APB_DW-1:0]   pwdata,
    output logic [ifb_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int unsigned NUM_W      = ifb_pkg::NUM_W;
    localparam int unsigned CFG_W      = ifb_pkg::CFG_W;
    localparam int unsigned BLOCK_BITS = BLOCK_BYTES * ifb_pkg::BYTE_BITS;
    localparam int unsigned TOTAL_BITS = MAX_MAP_BLOCKS * BLOCK_BITS;
    localparam int unsigned WORD_COUNT = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int unsigned BW         = $clog2(WORD_BITS);
    localparam int unsigned LIM_W      = $clog2(TOTAL_BITS + 1);
    localparam int unsigned CMP_W      = (LIM_W > NUM_W) ? LIM_W + 1 : NUM_W + 1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] map_blocks_reg;
    logic             cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == 1'b0);
    assign prdata  = cfg_sel ? ifb_pkg::APB_DW'(map_blocks_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_blocks_reg <= ifb_pkg::MAP_BLOCKS_RST;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            map_blocks_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Number of valid map bits; a block count above the maximum is clamped.
    logic [LIM_W-1:0] limit;

    always_comb
    begin
        if (32'(map_blocks_reg) > MAX_MAP_BLOCKS)
        begin
            limit = LIM_W'(TOTAL_BITS);
        end
        else
        begin
            limit = LIM_W'(LIM_W'(map_blocks_reg) * LIM_W'(BLOCK_BITS));
        end
    end

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    ifb_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg;
    ifb_pkg::func_t   func_reg;
    logic [NUM_W-1:0] idx_reg;
    logic [AW-1:0]    scan_addr_reg;
    logic [LIM_W-1:0] base_reg;
    logic [LIM_W-1:0] rem_reg;
    logic [WORD_BITS-1:0] vmask_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] cand_reg;
    ifb_pkg::status_t res_status_reg;
    logic [NUM_W-1:0] res_num_reg;
    logic             out_valid_reg;
    logic [ifb_pkg::TDATA_W-1:0] out_data_reg;

    // input decode
    ifb_pkg::func_t   in_func;
    logic [NUM_W-1:0] in_num;
    logic             accept;
    logic             out_of_range;

    assign in_func  = ifb_pkg::func_t'(s_tdata[1:0]);
    assign in_num   = s_tdata[NUM_W+1:2];
    assign s_tready = (state_reg == ifb_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign out_of_range = (in_num == '0) ||
                          ((CMP_W'(in_num) - CMP_W'(1)) >= CMP_W'(limit));

    // RAM port
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    ifb_ram #(
        .WIDTH  (WORD_BITS),
        .DEPTH  (WORD_COUNT),
        .ADDR_W (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Word and bit position of a free or mark target
    logic [AW-1:0] split_word;
    logic [BW-1:0] split_bit;

    ifb_split #(
        .WORD_BITS (WORD_BITS),
        .ADDR_W    (AW),
        .BIT_W     (BW)
    ) u_split (
        .clk      (clk),
        .idx      (idx_reg),
        .word_idx (split_word),
        .bit_idx  (split_bit)
    );

    // ------------------------------------------------------------------
    // Scan helpers
    // ------------------------------------------------------------------
    logic [LIM_W-1:0]     rem_next;
    logic [LIM_W-1:0]     mask_src;
    logic [WORD_BITS-1:0] vmask_new;
    logic [WORD_BITS-1:0] cand;
    logic                 cand_full;
    logic                 last_word;
    logic [BW-1:0]        pick_bit;
    logic [NUM_W-1:0]     granted;
    logic [WORD_BITS-1:0] split_onehot;
    logic                 split_set;
    logic                 clr_last;

    assign rem_next  = rem_reg - LIM_W'(WORD_BITS);
    assign last_word = (rem_reg <= LIM_W'(WORD_BITS));
    assign mask_src  = (state_reg == ifb_pkg::S_IDLE) ? limit : rem_next;

    // bits past the end of the map in use count as taken
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            vmask_new[i] = (CMP_W'(i) < CMP_W'(mask_src));
        end
    end

    assign cand      = ram_rdata | ~vmask_reg;
    assign cand_full = &cand;

    // lowest clear bit of the candidate word
    always_comb
    begin
        pick_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!cand_reg[i])
            begin
                pick_bit = BW'(i);
            end
        end
    end

    assign granted = NUM_W'(CMP_W'(base_reg) + CMP_W'(pick_bit) + CMP_W'(1));

    assign split_onehot = WORD_BITS'(1) << split_bit;
    assign split_set    = ram_rdata[split_bit];
    assign clr_last     = (clr_addr_reg == AW'(WORD_COUNT - 1));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ifb_pkg::S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ifb_pkg::S_IDLE;
                end
            end
            ifb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_func)
                        ifb_pkg::FUNC_ALLOC:
                            state_next = (limit == '0) ? ifb_pkg::S_DONE : ifb_pkg::S_SCAN;
                        ifb_pkg::FUNC_FREE,
                        ifb_pkg::FUNC_MARK:
                            state_next = out_of_range ? ifb_pkg::S_DONE
                                                      : ifb_pkg::S_SPLIT_A;
                        default:
                            state_next = ifb_pkg::S_DONE;
                    endcase
                end
            end
            ifb_pkg::S_SPLIT_A: state_next = ifb_pkg::S_SPLIT_B;
            ifb_pkg::S_SPLIT_B: state_next = ifb_pkg::S_ISSUE;
            ifb_pkg::S_ISSUE:   state_next = ifb_pkg::S_MODIFY;
            ifb_pkg::S_MODIFY:  state_next = ifb_pkg::S_DONE;
            ifb_pkg::S_SCAN:
            begin
                if (!cand_full)
                begin
                    state_next = ifb_pkg::S_PICK;
                end
                else if (last_word)
                begin
                    state_next = ifb_pkg::S_DONE;
                end
            end
            ifb_pkg::S_PICK:    state_next = ifb_pkg::S_DONE;
            ifb_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ifb_pkg::S_IDLE;
                end
            end
            default:            state_next = ifb_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // RAM controls
    // ------------------------------------------------------------------
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = '0;
        unique case (state_reg)
            ifb_pkg::S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_addr_reg;
            end
            ifb_pkg::S_SCAN:
            begin
                // prefetch the next word while this one is checked
                ram_addr = scan_addr_reg + AW'(1);
            end
            ifb_pkg::S_ISSUE:
            begin
                ram_addr = split_word;
            end
            ifb_pkg::S_MODIFY:
            begin
                ram_addr = split_word;
                if (func_reg == ifb_pkg::FUNC_FREE)
                begin
                    ram_we    = split_set;
                    ram_wdata = ram_rdata & ~split_onehot;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | split_onehot;
                end
            end
            ifb_pkg::S_PICK:
            begin
                ram_we    = 1'b1;
                ram_addr  = scan_addr_reg;
                ram_wdata = word_reg | (WORD_BITS'(1) << pick_bit);
            end
            default:
            begin
                ram_addr = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ifb_pkg::S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ifb_pkg::S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (state_reg == ifb_pkg::S_DONE && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ifb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    func_reg      <= in_func;
                    idx_reg       <= in_num - NUM_W'(1);
                    scan_addr_reg <= '0;
                    base_reg      <= '0;
                    rem_reg       <= limit;
                    vmask_reg     <= vmask_new;
                    res_num_reg   <= '0;
                    unique case (in_func)
                        ifb_pkg::FUNC_ALLOC:
                            res_status_reg <= (limit == '0) ? ifb_pkg::ST_FULL
                                                            : ifb_pkg::ST_OK;
                        ifb_pkg::FUNC_FREE,
                        ifb_pkg::FUNC_MARK:
                            res_status_reg <= out_of_range ? ifb_pkg::ST_RANGE
                                                           : ifb_pkg::ST_OK;
                        default:
                            res_status_reg <= ifb_pkg::ST_OK;
                    endcase
                end
            end
            ifb_pkg::S_SCAN:
            begin
                if (!cand_full)
                begin
                    word_reg <= ram_rdata;
                    cand_reg <= cand;
                end
                else if (last_word)
                begin
                    res_status_reg <= ifb_pkg::ST_FULL;
                end
                else
                begin
                    // advance to the prefetched word
                    scan_addr_reg <= scan_addr_reg + AW'(1);
                    base_reg      <= base_reg + LIM_W'(WORD_BITS);
                    rem_reg       <= rem_next;
                    vmask_reg     <= vmask_new;
                end
            end
            ifb_pkg::S_PICK:
            begin
                res_status_reg <= ifb_pkg::ST_OK;
                res_num_reg    <= granted;
            end
            ifb_pkg::S_MODIFY:
            begin
                if (func_reg == ifb_pkg::FUNC_FREE && !split_set)
                begin
                    res_status_reg <= ifb_pkg::ST_NOT_ALLOC;
                end
            end
            ifb_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_reg <= ifb_pkg::TDATA_W'({res_num_reg, res_status_reg});
                end
            end
            default:
            begin
                word_reg <= word_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/ifb_checker.sv]
`timescale 1ns / 1ps

module ifb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [ifb_pkg::TDATA_W-1:0] s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [ifb_pkg::TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // clearing pass keeps both sides quiet right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !s_tready && !m_tvalid)
        else $error("block active during map clear");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transfer taken while busy");

    // a result with an error status carries no number
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != ifb_pkg::ST_OK) |-> m_tdata[18:2] == '0)
        else $error("number granted with error status");

    // an offered transfer that is not yet taken stays valid and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input dropped before transfer");

endmodule

bind inode_bitmap_allocator_top ifb_checker u_ifb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
